// File: hdl/dss_pkg.sv
package dss_pkg;

  // Action codes as they arrive on the input channel
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_SET_L   = 3'd1;
  localparam logic [2:0] ACT_SET_R   = 3'd2;
  localparam logic [2:0] ACT_ENABLE  = 3'd3;
  localparam logic [2:0] ACT_DISABLE = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;

  localparam int ACT_W    = 3;
  localparam int SPEED_W  = 16;
  localparam int IVAL_W   = 20;
  localparam int PERIOD_W = 24;
  localparam int CFG_W    = 24;
  localparam int TALLY_W  = 32;
  localparam int MEAS_W   = 32;

  // Shared divider: read dividend is |sum| (33 bits) times 450000 (19 bits)
  localparam int DIVIDEND_W = 52;
  localparam int DIVISOR_W  = 33;
  localparam int DIV_CNT_W  = 6;
  localparam int SUM_W      = TALLY_W + 1;

  localparam logic [18:0] RATE_SCALE = 19'd450000;

  localparam logic [IVAL_W-1:0]   MIN_IVAL_RST = 20'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd10000;

  localparam logic signed [TALLY_W-1:0] TALLY_MAX = 32'sh7fff_ffff;
  localparam logic signed [TALLY_W-1:0] TALLY_MIN = 32'sh8000_0000;

  localparam logic [0:0] REG_MIN_IVAL = 1'b0;
  localparam logic [0:0] REG_PERIOD   = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_L,
    OP_SET_R,
    OP_ENABLE,
    OP_DISABLE,
    OP_READ,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    MOV_STOP,
    MOV_FWD,
    MOV_BACK
  } motion_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [SPEED_W-1:0] speed;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// File: hdl/dss_front.sv
module dss_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dss_pkg::ACT_W-1:0]            action,
  input  logic signed [dss_pkg::SPEED_W-1:0]   speed_dps,
  input  dss_pkg::queue_status_t               q_status,
  output logic                                 push,
  output dss_pkg::cmd_t                        cmd
);
  import dss_pkg::*;

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classify the raw action code; unknown codes become a no-op
  always_comb begin
    cmd.speed = speed_dps;
    case (action)
      ACT_TICK:    cmd.op = OP_TICK;
      ACT_SET_L:   cmd.op = OP_SET_L;
      ACT_SET_R:   cmd.op = OP_SET_R;
      ACT_ENABLE:  cmd.op = OP_ENABLE;
      ACT_DISABLE: cmd.op = OP_DISABLE;
      ACT_READ:    cmd.op = OP_READ;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/dss_queue.sv
module dss_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dss_pkg::cmd_t          wr_cmd,
  input  logic                   pop,
  output dss_pkg::cmd_t          rd_cmd,
  output dss_pkg::queue_status_t status
);
  import dss_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

  assign rd_cmd       = entries[rd_ptr];
  assign status.valid = (fill != '0);
  assign status.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// File: hdl/dss_back.sv
module dss_back #(
  parameter int MICROSTEPS = 16,
  parameter int TIMER_HZ   = 1000000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dss_pkg::CFG_W-1:0]           cfg_data,
  input  dss_pkg::cmd_t                       q_cmd,
  input  logic                                q_valid,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                left_step,
  output logic                                right_step,
  output logic                                left_dir,
  output logic                                right_dir,
  output logic                                enable_n,
  output logic                                clamped,
  output logic                                speed_valid,
  output logic signed [dss_pkg::MEAS_W-1:0]   measured_speed
);
  import dss_pkg::*;

  localparam logic [DIVIDEND_W-1:0] SPEED_NUM = DIVIDEND_W'(TIMER_HZ * 9);
  localparam logic [DIVISOR_W-1:0]  SPEED_K   = DIVISOR_W'(10 * MICROSTEPS);
  localparam logic [DIVISOR_W-1:0]  READ_K    = DIVISOR_W'(MICROSTEPS);
  localparam logic [IVAL_W-1:0]     IVAL_RST  = IVAL_W'(TIMER_HZ);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST  = DIV_CNT_W'(DIVIDEND_W - 1);

  state_t state, state_next;

  logic                        enabled, enabled_next;
  logic [1:0]                  level, level_next;
  motion_t                     motion [2];
  motion_t                     motion_next [2];
  logic [IVAL_W-1:0]           interval [2];
  logic [IVAL_W-1:0]           interval_next [2];
  logic [IVAL_W-1:0]           count [2];
  logic [IVAL_W-1:0]           count_next [2];
  logic signed [TALLY_W-1:0]   tally [2];
  logic signed [TALLY_W-1:0]   tally_next [2];
  logic [IVAL_W-1:0]           min_interval;
  logic [PERIOD_W-1:0]         sample_period_us;

  // Divider working set
  op_t                   op, op_next;
  logic                  neg, neg_next;
  logic [SUM_W-1:0]      sum_mag, sum_mag_next;
  logic [DIVIDEND_W-1:0] dvd, dvd_next;
  logic [DIVISOR_W-1:0]  dsr, dsr_next;
  logic [DIVISOR_W-1:0]  rem, rem_next;
  logic [DIVIDEND_W-1:0] quo, quo_next;
  logic [DIV_CNT_W-1:0]  cnt, cnt_next;

  logic                  res_free;
  logic                  load_res;
  logic                  res_clamp;
  logic                  res_sv;
  logic [MEAS_W-1:0]     res_meas;

  assign res_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && res_free) begin
          if ((q_cmd.op == OP_SET_L || q_cmd.op == OP_SET_R) && q_cmd.speed != '0)
            state_next = ST_DIV;
          else if (q_cmd.op == OP_READ)
            state_next = ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (cnt == '0) state_next = ST_FINISH;
      ST_FINISH: if (res_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    logic [IVAL_W-1:0]       cnt_inc;
    logic [SPEED_W-1:0]      mag;
    logic [SUM_W-1:0]        sum;
    logic [DIVISOR_W:0]      rem_sh;
    logic [DIVIDEND_W-1:0]   ival;
    logic [PERIOD_W-1:0]     per;
    logic                    ch;

    enabled_next = enabled;
    level_next   = level;
    motion_next  = motion;
    interval_next = interval;
    count_next   = count;
    tally_next   = tally;
    op_next      = op;
    neg_next     = neg;
    sum_mag_next = sum_mag;
    dvd_next     = dvd;
    dsr_next     = dsr;
    rem_next     = rem;
    quo_next     = quo;
    cnt_next     = cnt;
    q_pop        = 1'b0;
    load_res     = 1'b0;
    res_clamp    = 1'b0;
    res_sv       = 1'b0;
    res_meas     = '0;
    cnt_inc      = '0;
    ival         = '0;
    rem_sh       = '0;
    mag = q_cmd.speed[SPEED_W-1] ? SPEED_W'(-q_cmd.speed) : SPEED_W'(q_cmd.speed);
    sum = {tally[0][TALLY_W-1], tally[0]} + {tally[1][TALLY_W-1], tally[1]};
    per = (sample_period_us == '0) ? PERIOD_W'(1) : sample_period_us;
    ch  = (q_cmd.op == OP_SET_R);

    case (state)
      ST_IDLE: begin
        if (q_valid && res_free) begin
          q_pop   = 1'b1;
          op_next = q_cmd.op;
          case (q_cmd.op)
            OP_TICK: begin
              load_res = 1'b1;
              if (enabled) begin
                for (int i = 0; i < 2; i++) begin
                  if (motion[i] != MOV_STOP) begin
                    cnt_inc = count[i] + IVAL_W'(1);
                    if (cnt_inc >= interval[i]) begin
                      count_next[i] = '0;
                      level_next[i] = ~level[i];
                      if (motion[i] == MOV_FWD) begin
                        if (tally[i] != TALLY_MAX) tally_next[i] = tally[i] + 32'sd1;
                      end else begin
                        if (tally[i] != TALLY_MIN) tally_next[i] = tally[i] - 32'sd1;
                      end
                    end else begin
                      count_next[i] = cnt_inc;
                    end
                  end
                end
              end
            end
            OP_SET_L, OP_SET_R: begin
              neg_next = q_cmd.speed[SPEED_W-1];
              if (q_cmd.speed == '0) begin
                // Stopped channel: fixed interval, no division
                load_res = 1'b1;
                motion_next[ch] = MOV_STOP;
                if (IVAL_RST < min_interval) begin
                  interval_next[ch] = min_interval;
                  res_clamp = 1'b1;
                end else begin
                  interval_next[ch] = IVAL_RST;
                end
              end else begin
                dvd_next = SPEED_NUM;
                dsr_next = DIVISOR_W'(SPEED_K * DIVISOR_W'(mag));
                rem_next = '0;
                cnt_next = DIV_LAST;
              end
            end
            OP_READ: begin
              neg_next      = sum[SUM_W-1];
              sum_mag_next  = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
              dsr_next      = DIVISOR_W'(READ_K * DIVISOR_W'(per));
              rem_next      = '0;
              cnt_next      = DIV_LAST;
              tally_next[0] = '0;
              tally_next[1] = '0;
            end
            OP_ENABLE: begin
              enabled_next = 1'b1;
              load_res     = 1'b1;
            end
            OP_DISABLE: begin
              enabled_next = 1'b0;
              load_res     = 1'b1;
            end
            default: load_res = 1'b1;
          endcase
        end
      end
      ST_MUL: begin
        dvd_next = DIVIDEND_W'(sum_mag) * DIVIDEND_W'(RATE_SCALE);
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle
        rem_sh   = {rem, dvd[DIVIDEND_W-1]};
        dvd_next = {dvd[DIVIDEND_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, dsr}) begin
          rem_next = DIVISOR_W'(rem_sh - {1'b0, dsr});
          quo_next = {quo[DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem_next = rem_sh[DIVISOR_W-1:0];
          quo_next = {quo[DIVIDEND_W-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
      end
      ST_FINISH: begin
        if (res_free) begin
          load_res = 1'b1;
          if (op == OP_READ) begin
            res_sv = 1'b1;
            if (!neg) begin
              res_meas = (quo > DIVIDEND_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo[MEAS_W-1:0];
            end else begin
              res_meas = (quo > DIVIDEND_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                    : MEAS_W'(-quo[MEAS_W-1:0]);
            end
          end else begin
            ival = quo;
            motion_next[op == OP_SET_R] = neg ? MOV_BACK : MOV_FWD;
            if (ival < DIVIDEND_W'(min_interval)) begin
              interval_next[op == OP_SET_R] = min_interval;
              res_clamp = 1'b1;
            end else begin
              interval_next[op == OP_SET_R] = ival[IVAL_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      enabled          <= 1'b0;
      level            <= '0;
      out_valid        <= 1'b0;
      min_interval     <= MIN_IVAL_RST;
      sample_period_us <= PERIOD_RST;
      for (int i = 0; i < 2; i++) begin
        motion[i]   <= MOV_STOP;
        interval[i] <= IVAL_RST;
        count[i]    <= '0;
        tally[i]    <= '0;
      end
    end else begin
      state     <= state_next;
      enabled   <= enabled_next;
      level     <= level_next;
      out_valid <= load_res || (out_valid && !out_ready);
      motion    <= motion_next;
      interval  <= interval_next;
      count     <= count_next;
      tally     <= tally_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_IVAL: min_interval     <= cfg_data[IVAL_W-1:0];
          REG_PERIOD:   sample_period_us <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    neg     <= neg_next;
    sum_mag <= sum_mag_next;
    dvd     <= dvd_next;
    dsr     <= dsr_next;
    rem     <= rem_next;
    quo     <= quo_next;
    cnt     <= cnt_next;
    if (load_res) begin
      left_step      <= level_next[0];
      right_step     <= level_next[1];
      left_dir       <= (motion_next[0] == MOV_BACK);
      right_dir      <= (motion_next[1] == MOV_BACK);
      enable_n       <= !enabled_next;
      clamped        <= res_clamp;
      speed_valid    <= res_sv;
      measured_speed <= res_meas;
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("queue popped while an item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_res)
    else $error("result register overwritten before it was taken");

  a_reset_disabled: assert property (@(posedge clk)
    rst |=> !enabled && state == ST_IDLE)
    else $error("block not idle and disabled after reset");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != '0) |=> state == ST_DIV)
    else $error("division left before its last step");

endmodule

// File: hdl/dual_stepper_step_generator.sv
// Dual stepper step/direction generator.
// Input channel (in_valid/in_ready): one word per item carrying action and
// speed_dps: tick, set left or right speed, enable, disable or read speed.
// Output channel (out_valid/out_ready): exactly one result word per item,
// showing step and direction levels, enable_n, the clamp flag and, for a
// read, the averaged speed.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 min_interval, 1 sample_period_us); write only while the block is idle.
// A front stage decodes words into a four-entry queue; the back end works
// through them one at a time. Tick, enable, disable and zero-speed words are
// done in the idle state, which loads the result register as it pops them.
// A nonzero set-speed runs the shared restoring divider, one quotient bit a
// cycle over 52 bits; a read first passes through a multiply state. The back
// end takes no new word until such a division is through and its result loaded.
// Reset clears the queue, disables the motors, stops both channels and
// restores the register defaults. When the receiver stalls, the result
// word holds in the output register; the queue still takes words until full.
module dual_stepper_step_generator #(
  parameter int MICROSTEPS = 16,
  parameter int TIMER_HZ   = 1000000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dss_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dss_pkg::ACT_W-1:0]           action,
  input  logic signed [dss_pkg::SPEED_W-1:0]  speed_dps,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                left_step,
  output logic                                right_step,
  output logic                                left_dir,
  output logic                                right_dir,
  output logic                                enable_n,
  output logic                                clamped,
  output logic                                speed_valid,
  output logic signed [dss_pkg::MEAS_W-1:0]   measured_speed
);
  import dss_pkg::*;

  queue_status_t q_status;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          push;
  logic          pop;

  // Decode and admit words while the queue has room
  dss_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .speed_dps (speed_dps),
    .q_status  (q_status),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Hold decoded words between front and back
  dss_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .status (q_status)
  );

  // Advance timers, divide and drive the result register
  dss_back #(
    .MICROSTEPS (MICROSTEPS),
    .TIMER_HZ   (TIMER_HZ)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_cmd          (head_cmd),
    .q_valid        (q_status.valid),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_step      (left_step),
    .right_step     (right_step),
    .left_dir       (left_dir),
    .right_dir      (right_dir),
    .enable_n       (enable_n),
    .clamped        (clamped),
    .speed_valid    (speed_valid),
    .measured_speed (measured_speed)
  );

endmodule
